// File: rtl/core/cpu_control_flow_unit_macros.svh
// Assertion macros used by the control-flow unit checker.
`ifndef CPU_CONTROL_FLOW_UNIT_MACROS_SVH
`define CPU_CONTROL_FLOW_UNIT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock and idle during reset.
`define CCFU_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Implication whose consequent starts in the cycle after the antecedent.
`define CCFU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> cons) \
      else $error(msg);

`endif

// File: rtl/core/ccfu_pkg.sv
package ccfu_pkg;

   // Input item of one control-flow instruction.
   typedef struct packed {
      logic [7:0]  opcode;
      logic [15:0] pc_in;
      logic [15:0] sp_in;
      logic [7:0]  imm_lo;
      logic [7:0]  imm_hi;
      logic        zero_flag;
      logic        carry_flag;
      logic [15:0] hl_value;
      logic [7:0]  stack_lo;
      logic [7:0]  stack_hi;
   } ccfu_req_type;

   // Result of one instruction.
   typedef struct packed {
      logic [15:0] pc_out;
      logic [15:0] sp_out;
      logic        push_enable;
      logic [7:0]  push_hi;
      logic [7:0]  push_lo;
      logic        branch_taken;
      logic        ime_set;
      logic [2:0]  cycles;
      logic        illegal;
   } ccfu_rsp_type;

   // Opcodes.
   localparam logic [7:0] OP_JR      = 8'h18;
   localparam logic [7:0] OP_JR_NZ   = 8'h20;
   localparam logic [7:0] OP_JR_Z    = 8'h28;
   localparam logic [7:0] OP_JR_NC   = 8'h30;
   localparam logic [7:0] OP_JR_C    = 8'h38;
   localparam logic [7:0] OP_JP      = 8'hC3;
   localparam logic [7:0] OP_JP_NZ   = 8'hC2;
   localparam logic [7:0] OP_JP_Z    = 8'hCA;
   localparam logic [7:0] OP_JP_NC   = 8'hD2;
   localparam logic [7:0] OP_JP_C    = 8'hDA;
   localparam logic [7:0] OP_JP_HL   = 8'hE9;
   localparam logic [7:0] OP_CALL    = 8'hCD;
   localparam logic [7:0] OP_CALL_NZ = 8'hC4;
   localparam logic [7:0] OP_CALL_Z  = 8'hCC;
   localparam logic [7:0] OP_CALL_NC = 8'hD4;
   localparam logic [7:0] OP_CALL_C  = 8'hDC;
   localparam logic [7:0] OP_RET     = 8'hC9;
   localparam logic [7:0] OP_RETI    = 8'hD9;
   localparam logic [7:0] OP_RET_NZ  = 8'hC0;
   localparam logic [7:0] OP_RET_Z   = 8'hC8;
   localparam logic [7:0] OP_RET_NC  = 8'hD0;
   localparam logic [7:0] OP_RET_C   = 8'hD8;

   // RST opcodes match 11xxx111; bits 5..3 give the vector.
   localparam logic [7:0] RST_MASK     = 8'hC7;
   localparam logic [7:0] RST_VEC_MASK = 8'h38;

   // Condition codes in opcode bits 4..3.
   localparam logic [1:0] COND_NZ = 2'd0;
   localparam logic [1:0] COND_Z  = 2'd1;
   localparam logic [1:0] COND_NC = 2'd2;
   localparam logic [1:0] COND_C  = 2'd3;

   // Machine cycle counts.
   localparam logic [2:0] CYC_NONE       = 3'd0;
   localparam logic [2:0] CYC_JP_HL      = 3'd1;
   localparam logic [2:0] CYC_SHORT      = 3'd2;
   localparam logic [2:0] CYC_JR_TAKEN   = 3'd3;
   localparam logic [2:0] CYC_SKIP_IMM16 = 3'd3;
   localparam logic [2:0] CYC_JP_TAKEN   = 3'd4;
   localparam logic [2:0] CYC_RET        = 3'd4;
   localparam logic [2:0] CYC_RST        = 3'd4;
   localparam logic [2:0] CYC_RET_TAKEN  = 3'd5;
   localparam logic [2:0] CYC_CALL_TAKEN = 3'd6;

endpackage

// File: rtl/core/cpu_control_flow_unit.sv
// Control-flow execute unit: JR, JP, CALL, RET, RETI and RST.
// Structure: the input register (req_ff) loads on a start transfer, and the result register
// (rsp_ff) captures the decoded result and drives the result strobe and result item.
// Throughput: one instruction per cycle; busy never asserts and the receiver cannot stall.
// Reset (synchronous, active high) clears both valid bits; no result is
// strobed until a new transfer has passed through.
module cpu_control_flow_unit (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  ccfu_pkg::ccfu_req_type req_item,
   output logic                  rsp_strobe,
   output ccfu_pkg::ccfu_rsp_type rsp_item
);

   ccfu_pkg::ccfu_req_type req_ff;
   logic                   req_valid_ff;
   ccfu_pkg::ccfu_rsp_type rsp_ff;
   ccfu_pkg::ccfu_rsp_type rsp_in;
   logic                   rsp_valid_ff;

   logic        cond;
   logic        go;
   logic [15:0] pc_plus1;
   logic [15:0] pc_plus2;
   logic [15:0] sp_plus2;
   logic [15:0] sp_minus2;
   logic [15:0] imm16;
   logic [15:0] popped;
   logic [15:0] jr_offset;
   logic [7:0]  op;

   assign busy = 1'b0;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= start;
      end
      if (start) begin
         req_ff <= req_item;
      end
   end

   // Shared address arithmetic.
   assign op        = req_ff.opcode;
   assign pc_plus1  = req_ff.pc_in + 16'd1;
   assign pc_plus2  = req_ff.pc_in + 16'd2;
   assign sp_plus2  = req_ff.sp_in + 16'd2;
   assign sp_minus2 = req_ff.sp_in - 16'd2;
   assign imm16     = {req_ff.imm_hi, req_ff.imm_lo};
   assign popped    = {req_ff.stack_hi, req_ff.stack_lo};
   assign jr_offset = {{8{req_ff.imm_lo[7]}}, req_ff.imm_lo};

   // Condition select from the opcode.
   always_comb begin
      case (op[4:3])
         ccfu_pkg::COND_NZ: cond = !req_ff.zero_flag;
         ccfu_pkg::COND_Z:  cond = req_ff.zero_flag;
         ccfu_pkg::COND_NC: cond = !req_ff.carry_flag;
         ccfu_pkg::COND_C:  cond = req_ff.carry_flag;
         default:           cond = 1'b0;
      endcase
   end

   // Unconditional forms always branch.
   assign go = cond || (op == ccfu_pkg::OP_JR) || (op == ccfu_pkg::OP_JP)
            || (op == ccfu_pkg::OP_CALL);

   // Instruction decode and result formation.
   always_comb begin
      rsp_in              = '0;
      rsp_in.pc_out       = req_ff.pc_in;
      rsp_in.sp_out       = req_ff.sp_in;
      case (op)
         ccfu_pkg::OP_JR, ccfu_pkg::OP_JR_NZ, ccfu_pkg::OP_JR_Z,
         ccfu_pkg::OP_JR_NC, ccfu_pkg::OP_JR_C: begin
            rsp_in.pc_out       = go ? pc_plus1 + jr_offset : pc_plus1;
            rsp_in.branch_taken = go;
            rsp_in.cycles       = go ? ccfu_pkg::CYC_JR_TAKEN : ccfu_pkg::CYC_SHORT;
         end
         ccfu_pkg::OP_JP, ccfu_pkg::OP_JP_NZ, ccfu_pkg::OP_JP_Z,
         ccfu_pkg::OP_JP_NC, ccfu_pkg::OP_JP_C: begin
            rsp_in.pc_out       = go ? imm16 : pc_plus2;
            rsp_in.branch_taken = go;
            rsp_in.cycles       = go ? ccfu_pkg::CYC_JP_TAKEN : ccfu_pkg::CYC_SKIP_IMM16;
         end
         ccfu_pkg::OP_JP_HL: begin
            rsp_in.pc_out       = req_ff.hl_value;
            rsp_in.branch_taken = 1'b1;
            rsp_in.cycles       = ccfu_pkg::CYC_JP_HL;
         end
         ccfu_pkg::OP_CALL, ccfu_pkg::OP_CALL_NZ, ccfu_pkg::OP_CALL_Z,
         ccfu_pkg::OP_CALL_NC, ccfu_pkg::OP_CALL_C: begin
            rsp_in.pc_out       = go ? imm16 : pc_plus2;
            rsp_in.branch_taken = go;
            rsp_in.cycles       = go ? ccfu_pkg::CYC_CALL_TAKEN : ccfu_pkg::CYC_SKIP_IMM16;
            if (go) begin
               rsp_in.sp_out      = sp_minus2;
               rsp_in.push_enable = 1'b1;
               rsp_in.push_hi     = pc_plus2[15:8];
               rsp_in.push_lo     = pc_plus2[7:0];
            end
         end
         ccfu_pkg::OP_RET, ccfu_pkg::OP_RETI: begin
            rsp_in.pc_out       = popped;
            rsp_in.sp_out       = sp_plus2;
            rsp_in.branch_taken = 1'b1;
            rsp_in.ime_set      = (op == ccfu_pkg::OP_RETI);
            rsp_in.cycles       = ccfu_pkg::CYC_RET;
         end
         ccfu_pkg::OP_RET_NZ, ccfu_pkg::OP_RET_Z, ccfu_pkg::OP_RET_NC,
         ccfu_pkg::OP_RET_C: begin
            if (cond) begin
               rsp_in.pc_out = popped;
               rsp_in.sp_out = sp_plus2;
            end
            rsp_in.branch_taken = cond;
            rsp_in.cycles       = cond ? ccfu_pkg::CYC_RET_TAKEN : ccfu_pkg::CYC_SHORT;
         end
         default: begin
            if ((op & ccfu_pkg::RST_MASK) == ccfu_pkg::RST_MASK) begin
               // Restart: push the current PC and jump to the fixed vector.
               rsp_in.pc_out       = {8'h00, op & ccfu_pkg::RST_VEC_MASK};
               rsp_in.sp_out       = sp_minus2;
               rsp_in.push_enable  = 1'b1;
               rsp_in.push_hi      = req_ff.pc_in[15:8];
               rsp_in.push_lo      = req_ff.pc_in[7:0];
               rsp_in.branch_taken = 1'b1;
               rsp_in.cycles       = ccfu_pkg::CYC_RST;
            end else begin
               rsp_in.cycles  = ccfu_pkg::CYC_NONE;
               rsp_in.illegal = 1'b1;
            end
         end
      endcase
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= req_valid_ff;
      end
      if (req_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_item   = rsp_ff;

endmodule

// File: rtl/core/ccfu_checker.sv
`include "cpu_control_flow_unit_macros.svh"

module ccfu_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input ccfu_pkg::ccfu_req_type req_item,
   input logic                   rsp_strobe,
   input ccfu_pkg::ccfu_rsp_type rsp_item
);

   // Every accepted transfer produces a result after passing the input and result registers.
   `CCFU_ASSERT_NEXT(a_latency, start && !busy, ##1 rsp_strobe, "result strobe missing")

   // No result appears without an accepted transfer that has passed the input and result registers.
   `CCFU_ASSERT_NOW(a_no_spurious, rsp_strobe, $past(start && !busy, 2), "spurious result")

   // An illegal opcode leaves the stack untouched and costs nothing.
   `CCFU_ASSERT_NOW(a_illegal_quiet, rsp_strobe && rsp_item.illegal, !rsp_item.push_enable && !rsp_item.branch_taken && (rsp_item.cycles == ccfu_pkg::CYC_NONE) && (rsp_item.sp_out == $past(req_item.sp_in, 2)), "illegal opcode changed state")

   // A push always moves the stack pointer down by two.
   `CCFU_ASSERT_NOW(a_push_sp, rsp_strobe && rsp_item.push_enable, rsp_item.sp_out == ($past(req_item.sp_in, 2) - 16'd2), "push without stack decrement")

endmodule

bind cpu_control_flow_unit ccfu_checker u_ccfu_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_item   (req_item),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
